FILE: hw/rtl/crc8pd_pkg.sv
// Shared types, constants and the CRC-8 byte update for the frame deframer.
`timescale 1ns / 1ps

package crc8pd_pkg;

   // Register map indexes (byte address is four times the index).
   localparam logic [1:0] REG_SYNC_VALUE     = 2'd0;
   localparam logic [1:0] REG_LENGTH_LIMIT   = 2'd1;
   localparam logic [1:0] REG_CRC_POLYNOMIAL = 2'd2;
   localparam logic [1:0] REG_CRC_START      = 2'd3;

   // Width of the configuration address bus.
   localparam int CSR_ADDR_WIDTH = 4;

   // Register reset values.
   localparam logic [7:0]  SYNC_VALUE_RESET     = 8'hAA;
   localparam logic [15:0] LENGTH_LIMIT_RESET   = 16'd256;
   localparam logic [7:0]  CRC_POLYNOMIAL_RESET = 8'h8C;
   localparam logic [7:0]  CRC_START_RESET      = 8'h31;

   // Parser phases; the two remaining codes drop the byte and return to hunting.
   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_TYPE    = 3'd1,
      PH_LEN_LO  = 3'd2,
      PH_LEN_HI  = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_CRC     = 3'd5
   } phase_type;

   // Kinds of result transactions.
   typedef enum logic [1:0] {
      EV_DATA     = 2'd0,
      EV_GOOD     = 2'd1,
      EV_BAD      = 2'd2,
      EV_TOO_LONG = 2'd3
   } event_type;

   // Live configuration handed from the register block to the parser.
   typedef struct packed {
      logic [7:0]  sync_value;
      logic [15:0] length_limit;
      logic [7:0]  crc_polynomial;
      logic [7:0]  crc_start;
   } cfg_type;

   // One result item.
   typedef struct packed {
      event_type   event_kind;
      logic [7:0]  data_byte;
      logic [7:0]  packet_type;
      logic [15:0] packet_length;
      logic [7:0]  crc_received;
      logic [7:0]  crc_computed;
   } result_type;

   // MSB-first CRC-8 update over one byte, eight shift steps.
   function automatic logic [7:0] crc8_update(input logic [7:0] crc,
                                              input logic [7:0] data,
                                              input logic [7:0] poly);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ poly;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

FILE: hw/rtl/crc8_packet_deframer_top.sv
// Sync/type/length/payload/CRC-8 deframer: input byte channel, result channel, registers.
//
// Usage: received bytes enter on the req_ channel, one per transaction. The block
// hunts for the sync byte, reads a type byte and a little-endian 16-bit length,
// streams each payload byte out as a result, and closes the frame with a good or
// CRC-mismatch result when the trailing CRC byte arrives. A length above the
// limit gives a too-long result and the block hunts again.
// Results: a result appears on rsp_ in the cycle after the byte that causes it is
// accepted. Throughput: one byte per cycle unless stalled; parser state and CRC
// byte update complete in the acceptance cycle and feed a single result register.
// Bytes that cause no result (sync, header, hunting) are consumed with no output.
// Stalls: when the receiver holds rsp_ready low with a result waiting, req_ready
// drops until that result transaction completes; otherwise bytes keep flowing.
// Reset: synchronous and active high; registers return to their defaults, the
// parser hunts for sync and the result register is emptied.
// Registers (APB-style, byte address 4*i): sync value, length limit,
// CRC polynomial, CRC start value. Write them only while the block is idle.
`timescale 1ns / 1ps

module crc8_packet_deframer_top
   import crc8pd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // Input byte channel
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_rx_byte,
   // Result channel
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [1:0]                rsp_event_kind,
   output logic [7:0]                rsp_data_byte,
   output logic [7:0]                rsp_packet_type,
   output logic [15:0]               rsp_packet_length,
   output logic [7:0]                rsp_crc_received,
   output logic [7:0]                rsp_crc_computed,
   // Configuration port
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);

   cfg_type    cfg;
   logic       step;
   logic       result_valid;
   result_type result;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff;

   // Configuration registers.
   crc8pd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Accept a byte whenever the result register is empty or being drained.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign step      = req_valid && req_ready;

   // Frame parser.
   crc8pd_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .rx_byte      (req_rx_byte),
      .cfg          (cfg),
      .result_valid (result_valid),
      .result       (result)
   );

   // Result register valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = result_valid;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result register payload, loaded only with a new result.
   always_ff @(posedge clock) begin
      if (step && result_valid) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_event_kind    = rsp_data_ff.event_kind;
   assign rsp_data_byte     = rsp_data_ff.data_byte;
   assign rsp_packet_type   = rsp_data_ff.packet_type;
   assign rsp_packet_length = rsp_data_ff.packet_length;
   assign rsp_crc_received  = rsp_data_ff.crc_received;
   assign rsp_crc_computed  = rsp_data_ff.crc_computed;

endmodule

FILE: hw/rtl/crc8pd_csr.sv
// Configuration register block with an APB-style write and read port.
`timescale 1ns / 1ps

module crc8pd_csr
   import crc8pd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready,
   output cfg_type                   cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       write_en;
   logic [1:0] reg_index;

   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[3:2];
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Next register values for a completed write transaction.
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (reg_index)
            REG_SYNC_VALUE:     cfg_in.sync_value     = csr_pwdata[7:0];
            REG_LENGTH_LIMIT:   cfg_in.length_limit   = csr_pwdata[15:0];
            REG_CRC_POLYNOMIAL: cfg_in.crc_polynomial = csr_pwdata[7:0];
            REG_CRC_START:      cfg_in.crc_start      = csr_pwdata[7:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   // Register storage.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_value     <= SYNC_VALUE_RESET;
         cfg_ff.length_limit   <= LENGTH_LIMIT_RESET;
         cfg_ff.crc_polynomial <= CRC_POLYNOMIAL_RESET;
         cfg_ff.crc_start      <= CRC_START_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read data mux.
   always_comb begin
      case (reg_index)
         REG_SYNC_VALUE:     csr_prdata = {24'd0, cfg_ff.sync_value};
         REG_LENGTH_LIMIT:   csr_prdata = {16'd0, cfg_ff.length_limit};
         REG_CRC_POLYNOMIAL: csr_prdata = {24'd0, cfg_ff.crc_polynomial};
         REG_CRC_START:      csr_prdata = {24'd0, cfg_ff.crc_start};
         default:            csr_prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

FILE: hw/rtl/crc8pd_parser.sv
// Frame parser: phase state machine, header capture, payload count and CRC chain.
`timescale 1ns / 1ps

module crc8pd_parser
   import crc8pd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] rx_byte,
   input  cfg_type    cfg,
   output logic       result_valid,
   output result_type result
);

   phase_type   phase_ff, phase_in;
   logic [7:0]  frame_type_ff, frame_type_in;
   logic [15:0] frame_length_ff, frame_length_in;
   logic [15:0] bytes_seen_ff, bytes_seen_in;
   logic [7:0]  running_crc_ff, running_crc_in;

   logic [7:0]  crc_next;
   logic [15:0] length_full;
   logic [15:0] seen_plus_one;
   logic        too_long;

   assign crc_next      = crc8_update(running_crc_ff, rx_byte, cfg.crc_polynomial);
   assign length_full   = {rx_byte, frame_length_ff[7:0]};
   assign seen_plus_one = bytes_seen_ff + 16'd1;
   assign too_long      = length_full > cfg.length_limit;

   // Next phase and frame state for the byte in this transaction.
   always_comb begin
      phase_in        = phase_ff;
      frame_type_in   = frame_type_ff;
      frame_length_in = frame_length_ff;
      bytes_seen_in   = bytes_seen_ff;
      running_crc_in  = running_crc_ff;
      case (phase_ff)
         PH_HUNT: begin
            if (rx_byte == cfg.sync_value) begin
               running_crc_in = cfg.crc_start;
               phase_in       = PH_TYPE;
            end
         end
         PH_TYPE: begin
            frame_type_in  = rx_byte;
            running_crc_in = crc_next;
            phase_in       = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            frame_length_in = {8'd0, rx_byte};
            running_crc_in  = crc_next;
            phase_in        = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            frame_length_in = length_full;
            running_crc_in  = crc_next;
            bytes_seen_in   = 16'd0;
            if (too_long) begin
               phase_in = PH_HUNT;
            end else if (length_full == 16'd0) begin
               phase_in = PH_CRC;
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            running_crc_in = crc_next;
            bytes_seen_in  = seen_plus_one;
            if (seen_plus_one >= frame_length_ff) begin
               phase_in = PH_CRC;
            end
         end
         PH_CRC: begin
            phase_in = PH_HUNT;
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
   end

   // Result item produced by the byte in this transaction.
   always_comb begin
      result_valid         = 1'b0;
      result.event_kind    = EV_DATA;
      result.data_byte     = 8'd0;
      result.packet_type   = frame_type_ff;
      result.packet_length = frame_length_ff;
      result.crc_received  = 8'd0;
      result.crc_computed  = 8'd0;
      case (phase_ff)
         PH_LEN_HI: begin
            result.packet_length = length_full;
            if (too_long) begin
               result_valid      = 1'b1;
               result.event_kind = EV_TOO_LONG;
            end
         end
         PH_PAYLOAD: begin
            result_valid      = 1'b1;
            result.event_kind = EV_DATA;
            result.data_byte  = rx_byte;
         end
         PH_CRC: begin
            result_valid        = 1'b1;
            result.event_kind   = (rx_byte == running_crc_ff) ? EV_GOOD : EV_BAD;
            result.crc_received = rx_byte;
            result.crc_computed = running_crc_ff;
         end
         default: begin
            result_valid = 1'b0;
         end
      endcase
   end

   // State registers advance only on an accepted input transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HUNT;
         frame_type_ff   <= 8'd0;
         frame_length_ff <= 16'd0;
         bytes_seen_ff   <= 16'd0;
         running_crc_ff  <= CRC_START_RESET;
      end else if (step) begin
         phase_ff        <= phase_in;
         frame_type_ff   <= frame_type_in;
         frame_length_ff <= frame_length_in;
         bytes_seen_ff   <= bytes_seen_in;
         running_crc_ff  <= running_crc_in;
      end
   end

endmodule

FILE: test/tb_crc8_packet_deframer_top.sv
`timescale 1ns / 1ps
// Testbench for the CRC-8 packet deframer: directed frames, then random byte streams.

module tb_crc8_packet_deframer_top;
   import crc8pd_pkg::*;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int ITEMS_PER_PHASE = 250;
   localparam int NUM_PHASES      = 7;
   localparam int SETTLE_CYCLES   = 4;

   // How a directed row picks its byte: as written, or from the running CRC.
   typedef enum logic [1:0] {
      ROW_BYTE,
      ROW_CRC_OK,
      ROW_CRC_BAD
   } row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [7:0]   value;
      bit           typed;
      result_type   want;
   } stim_row_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic [7:0]                req_rx_byte;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic [1:0]                rsp_event_kind;
   logic [7:0]                rsp_data_byte;
   logic [7:0]                rsp_packet_type;
   logic [15:0]               rsp_packet_length;
   logic [7:0]                rsp_crc_received;
   logic [7:0]                rsp_crc_computed;
   logic                      csr_psel;
   logic                      csr_penable;
   logic                      csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [31:0]               csr_pwdata;
   logic [31:0]               csr_prdata;
   logic                      csr_pready;

   // Predictor copy of the registers and of the parser state.
   logic [7:0]  cfg_sync;
   logic [15:0] cfg_limit;
   logic [7:0]  cfg_poly;
   logic [7:0]  cfg_start;
   phase_type   fr_phase;
   logic [7:0]  fr_type;
   logic [15:0] fr_len;
   logic [15:0] fr_count;
   logic [7:0]  fr_crc;

   result_type   pending_results[$];
   stim_row_type directed_rows[$];

   // Typed expectation that goes with the byte on the input channel.
   bit          row_typed;
   result_type  row_want;

   logic [15:0] target_len;
   int          send_idle_pct;
   int          recv_stall_pct;
   int          fail_count;
   int          cycle_count;

   crc8_packet_deframer_top i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_packet_type   (rsp_packet_type),
      .rsp_packet_length (rsp_packet_length),
      .rsp_crc_received  (rsp_crc_received),
      .rsp_crc_computed  (rsp_crc_computed),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // MSB-first CRC-8 over one byte with the current polynomial.
   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] acc;
      acc = crc ^ b;
      repeat (8) acc = (acc << 1) ^ (acc[7] ? cfg_poly : 8'h00);
      return acc;
   endfunction

   // Advances the parser by one byte; returns 1 when the byte yields a result.
   function automatic bit deframe_byte(input logic [7:0] b, output result_type res);
      bit produced;
      produced = 1'b0;
      res = '0;
      case (fr_phase)
         PH_HUNT: begin
            if (b == cfg_sync) begin
               fr_crc = cfg_start;
               fr_phase = PH_TYPE;
            end
         end
         PH_TYPE: begin
            fr_type = b;
            fr_crc = crc8_step(fr_crc, b);
            fr_phase = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            fr_len = {8'h00, b};
            fr_crc = crc8_step(fr_crc, b);
            fr_phase = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            fr_len = {b, fr_len[7:0]};
            fr_crc = crc8_step(fr_crc, b);
            fr_count = '0;
            if (fr_len > cfg_limit) begin
               fr_phase = PH_HUNT;
               res.event_kind = EV_TOO_LONG;
               produced = 1'b1;
            end else if (fr_len == 16'd0) begin
               fr_phase = PH_CRC;
            end else begin
               fr_phase = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            fr_crc = crc8_step(fr_crc, b);
            fr_count = fr_count + 16'd1;
            if (fr_count >= fr_len) begin
               fr_phase = PH_CRC;
            end
            res.event_kind = EV_DATA;
            res.data_byte = b;
            produced = 1'b1;
         end
         PH_CRC: begin
            fr_phase = PH_HUNT;
            if (b == fr_crc) begin
               res.event_kind = EV_GOOD;
            end else begin
               res.event_kind = EV_BAD;
            end
            res.crc_received = b;
            res.crc_computed = fr_crc;
            produced = 1'b1;
         end
         default: begin
            fr_phase = PH_HUNT;
         end
      endcase
      res.packet_type = fr_type;
      res.packet_length = fr_len;
      return produced;
   endfunction

   // Picks the next random byte so that most of the stream forms valid frames.
   function automatic logic [7:0] next_stream_byte();
      logic [7:0]  b;
      logic [15:0] small_max;
      int          r;
      b = 8'($urandom_range(255));
      r = $urandom_range(99);
      // A few bytes are plain noise that breaks the frame they land in.
      if (r < 3 && !(cfg_limit > 16'd1024 && (fr_phase == PH_LEN_LO || fr_phase == PH_LEN_HI))) begin
         return b;
      end
      case (fr_phase)
         PH_HUNT: begin
            if (r < 75) begin
               b = cfg_sync;
            end
         end
         PH_LEN_LO: begin
            small_max = (cfg_limit < 16'd12) ? cfg_limit : 16'd12;
            r = $urandom_range(99);
            if (r < 10 && cfg_limit != 16'hFFFF) begin
               target_len = cfg_limit + 16'd1;
            end else if (r < 15) begin
               target_len = (cfg_limit == 16'hFFFF) ? 16'd0 : 16'hFFFF;
            end else if (r < 25) begin
               target_len = 16'd0;
            end else if ((r < 30 && cfg_limit <= 16'd32) || (r < 32 && cfg_limit <= 16'd300)) begin
               target_len = cfg_limit;
            end else begin
               target_len = 16'($urandom_range(0, small_max));
            end
            b = target_len[7:0];
         end
         PH_LEN_HI: begin
            b = target_len[15:8];
         end
         PH_PAYLOAD: begin
            if (r < 12) begin
               b = cfg_sync;
            end
         end
         PH_CRC: begin
            if (r < 80) begin
               b = fr_crc;
            end
         end
         default: begin
         end
      endcase
      return b;
   endfunction

   task automatic check_field(input string fname, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
         fail_count++;
      end
   endtask

   // Scoreboard: predicts on each accepted byte and checks each result transaction.
   always @(posedge clock) begin
      result_type predicted;
      result_type want;
      bit         produced;
      if (reset) begin
         cfg_sync  = SYNC_VALUE_RESET;
         cfg_limit = LENGTH_LIMIT_RESET;
         cfg_poly  = CRC_POLYNOMIAL_RESET;
         cfg_start = CRC_START_RESET;
         fr_phase  = PH_HUNT;
         fr_type   = '0;
         fr_len    = '0;
         fr_count  = '0;
         fr_crc    = CRC_START_RESET;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual event %0d data %h",
                        $time, rsp_event_kind, rsp_data_byte);
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               check_field("event_kind", 16'(want.event_kind), 16'(rsp_event_kind));
               check_field("data_byte", 16'(want.data_byte), 16'(rsp_data_byte));
               check_field("packet_type", 16'(want.packet_type), 16'(rsp_packet_type));
               check_field("packet_length", want.packet_length, rsp_packet_length);
               check_field("crc_received", 16'(want.crc_received), 16'(rsp_crc_received));
               check_field("crc_computed", 16'(want.crc_computed), 16'(rsp_crc_computed));
            end
         end
         if (req_valid && req_ready) begin
            produced = deframe_byte(req_rx_byte, predicted);
            if (produced || row_typed) begin
               pending_results.push_back(row_typed ? row_want : predicted);
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               REG_SYNC_VALUE:     cfg_sync  = csr_pwdata[7:0];
               REG_LENGTH_LIMIT:   cfg_limit = csr_pwdata[15:0];
               REG_CRC_POLYNOMIAL: cfg_poly  = csr_pwdata[7:0];
               REG_CRC_START:      cfg_start = csr_pwdata[7:0];
               default: begin
               end
            endcase
         end
      end
   end

   // Receiver back-pressure.
   always @(negedge clock) begin
      rsp_ready = ($urandom_range(99) >= recv_stall_pct);
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Offers one byte, entered and left at a falling edge.
   task automatic send_byte(input logic [7:0] b, input bit typed, input result_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_rx_byte = b;
      row_typed = typed;
      row_want = want;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Writes one register, then reads it back.
   task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
      logic [31:0] mask;
      logic [31:0] readback;
      mask = (idx == REG_LENGTH_LIMIT) ? 32'h0000_FFFF : 32'h0000_00FF;
      csr_psel = 1'b1;
      csr_pwrite = 1'b1;
      csr_penable = 1'b0;
      csr_paddr = {idx, 2'b00};
      csr_pwdata = {16'h0000, value};
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_pwrite = 1'b0;
      csr_penable = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      if (readback !== ({16'h0000, value} & mask)) begin
         $display("%0t: register %0d readback mismatch, expected %h, actual %h",
                  $time, idx, {16'h0000, value} & mask, readback);
         fail_count++;
      end
   endtask

   // Lets every outstanding result drain before the registers change.
   task automatic wait_idle();
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic void add_row(input row_kind_type kind, input logic [7:0] value,
                                   input bit typed, input result_type want);
      stim_row_type row;
      row.kind = kind;
      row.value = value;
      row.typed = typed;
      row.want = want;
      directed_rows.push_back(row);
   endfunction

   initial begin
      logic [7:0] b;
      fail_count = 0;
      cycle_count = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      row_typed = 1'b0;
      row_want = '0;
      target_len = '0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_rx_byte = '0;
      rsp_ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;

      // Directed frames under the reset register values.
      add_row(ROW_BYTE, 8'h00, 1'b0, '0);
      // Length one above the limit.
      add_row(ROW_BYTE, 8'hAA, 1'b0, '0);
      add_row(ROW_BYTE, 8'h5A, 1'b0, '0);
      add_row(ROW_BYTE, 8'h01, 1'b0, '0);
      add_row(ROW_BYTE, 8'h01, 1'b1,
              result_type'{EV_TOO_LONG, 8'h00, 8'h5A, 16'd257, 8'h00, 8'h00});
      // Largest length field and largest type.
      add_row(ROW_BYTE, 8'hAA, 1'b0, '0);
      add_row(ROW_BYTE, 8'hFF, 1'b0, '0);
      add_row(ROW_BYTE, 8'hFF, 1'b0, '0);
      add_row(ROW_BYTE, 8'hFF, 1'b1,
              result_type'{EV_TOO_LONG, 8'h00, 8'hFF, 16'hFFFF, 8'h00, 8'h00});
      // Zero-length frame closed by a wrong CRC byte.
      add_row(ROW_BYTE, 8'hAA, 1'b0, '0);
      add_row(ROW_BYTE, 8'h00, 1'b0, '0);
      add_row(ROW_BYTE, 8'h00, 1'b0, '0);
      add_row(ROW_BYTE, 8'h00, 1'b0, '0);
      add_row(ROW_CRC_BAD, 8'h00, 1'b0, '0);
      // Three payload bytes, the last one equal to the sync byte, then a good CRC.
      add_row(ROW_BYTE, 8'hAA, 1'b0, '0);
      add_row(ROW_BYTE, 8'h01, 1'b0, '0);
      add_row(ROW_BYTE, 8'h03, 1'b0, '0);
      add_row(ROW_BYTE, 8'h00, 1'b0, '0);
      add_row(ROW_BYTE, 8'h00, 1'b1,
              result_type'{EV_DATA, 8'h00, 8'h01, 16'd3, 8'h00, 8'h00});
      add_row(ROW_BYTE, 8'hFF, 1'b1,
              result_type'{EV_DATA, 8'hFF, 8'h01, 16'd3, 8'h00, 8'h00});
      add_row(ROW_BYTE, 8'hAA, 1'b1,
              result_type'{EV_DATA, 8'hAA, 8'h01, 16'd3, 8'h00, 8'h00});
      add_row(ROW_CRC_OK, 8'h00, 1'b0, '0);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         case (directed_rows[i].kind)
            ROW_CRC_OK:  b = fr_crc;
            ROW_CRC_BAD: b = fr_crc ^ 8'hFF;
            default:     b = directed_rows[i].value;
         endcase
         send_byte(b, directed_rows[i].typed, directed_rows[i].want);
      end

      // Random streams, each phase with its own register setting and one of four idling mixes.
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
            default: begin send_idle_pct = 10; recv_stall_pct = 10; end
         endcase
         if (ph == 1) begin
            write_register(REG_SYNC_VALUE, 16'h0000);
            write_register(REG_LENGTH_LIMIT, 16'h0000);
            write_register(REG_CRC_POLYNOMIAL, 16'h0000);
            write_register(REG_CRC_START, 16'h0000);
         end else if (ph == 2) begin
            write_register(REG_SYNC_VALUE, 16'h00FF);
            write_register(REG_LENGTH_LIMIT, 16'hFFFF);
            write_register(REG_CRC_POLYNOMIAL, 16'h00FF);
            write_register(REG_CRC_START, 16'h00FF);
         end else if (ph > 2) begin
            write_register(REG_SYNC_VALUE, 16'($urandom_range(255)));
            write_register(REG_LENGTH_LIMIT,
                           16'((ph % 2 == 0) ? $urandom_range(1, 40) : $urandom_range(65535)));
            write_register(REG_CRC_POLYNOMIAL, 16'($urandom_range(255)));
            write_register(REG_CRC_START, 16'($urandom_range(255)));
         end
         repeat (ITEMS_PER_PHASE) send_byte(next_stream_byte(), 1'b0, '0);
         wait_idle();
      end

      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
